// ----- rtl/h27i_pkg.sv -----
package h27i_pkg;

  localparam int NODE_COUNT          = 27;
  localparam int VALUE_BITS_DEF      = 24;
  localparam int COORD_FRAC_BITS_DEF = 14;
  localparam int COORD_BITS          = 16;
  localparam int POS_BITS            = 12;
  localparam int INDEX_BITS          = 5;
  localparam int QUEUE_DEPTH         = 2;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  // Node parameter along one axis: minus one, zero or plus one.
  typedef enum logic [1:0] {
    PAR_N = 2'd0,
    PAR_Z = 2'd1,
    PAR_P = 2'd2
  } par_t;

  // Node positions in hex27 order, one table per axis.
  localparam par_t NODE_S [NODE_COUNT] = '{
    PAR_N, PAR_P, PAR_P, PAR_N, PAR_N, PAR_P, PAR_P, PAR_N,
    PAR_Z, PAR_P, PAR_Z, PAR_N, PAR_Z, PAR_P, PAR_Z, PAR_N,
    PAR_N, PAR_P, PAR_P, PAR_N, PAR_Z, PAR_P, PAR_Z, PAR_N,
    PAR_Z, PAR_Z, PAR_Z
  };
  localparam par_t NODE_T [NODE_COUNT] = '{
    PAR_N, PAR_N, PAR_P, PAR_P, PAR_N, PAR_N, PAR_P, PAR_P,
    PAR_N, PAR_Z, PAR_P, PAR_Z, PAR_N, PAR_Z, PAR_P, PAR_Z,
    PAR_N, PAR_N, PAR_P, PAR_P, PAR_N, PAR_Z, PAR_P, PAR_Z,
    PAR_Z, PAR_Z, PAR_Z
  };
  localparam par_t NODE_U [NODE_COUNT] = '{
    PAR_N, PAR_N, PAR_N, PAR_N, PAR_P, PAR_P, PAR_P, PAR_P,
    PAR_N, PAR_N, PAR_N, PAR_N, PAR_P, PAR_P, PAR_P, PAR_P,
    PAR_Z, PAR_Z, PAR_Z, PAR_Z, PAR_Z, PAR_Z, PAR_Z, PAR_Z,
    PAR_N, PAR_P, PAR_Z
  };

  // Width of one queue entry: command, index, value, nine basis values,
  // three position fields and the last flag.
  function automatic int entry_bits(input int value_bits, input int frac_bits);
    return 1 + INDEX_BITS + value_bits + 9 * (frac_bits + 2) + 3 * POS_BITS + 1;
  endfunction

endpackage

// ----- rtl/h27i_queue.sv -----
module h27i_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/h27i_front.sv -----
module h27i_front #(
  parameter int VALUE_BITS      = h27i_pkg::VALUE_BITS_DEF,
  parameter int COORD_FRAC_BITS = h27i_pkg::COORD_FRAC_BITS_DEF,
  parameter int TDATA_BITS      = 120,
  parameter int ENTRY_BITS      = h27i_pkg::entry_bits(h27i_pkg::VALUE_BITS_DEF,
                                                       h27i_pkg::COORD_FRAC_BITS_DEF)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TDATA_BITS-1:0] in_data,
  input  logic                  in_cmd,
  input  logic                  in_last,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [ENTRY_BITS-1:0] q_data
);

  import h27i_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int CLW  = F + 2;
  localparam int CMPW = (COORD_BITS > CLW) ? COORD_BITS : CLW;
  localparam int SQW  = 2 * F + 1;
  localparam int RW   = 2 * F + 3;
  localparam int BW   = F + 2;

  localparam int OFF_V = INDEX_BITS;
  localparam int OFF_S = OFF_V + VALUE_BITS;
  localparam int OFF_T = OFF_S + COORD_BITS;
  localparam int OFF_U = OFF_T + COORD_BITS;
  localparam int OFF_X = OFF_U + COORD_BITS;
  localparam int OFF_Y = OFF_X + POS_BITS;
  localparam int OFF_Z = OFF_Y + POS_BITS;

  localparam logic signed [CMPW-1:0] ONE_C = CMPW'(64'd1 << F);
  localparam logic signed [RW-1:0]   ONE2  = RW'(64'd1 << (2 * F));
  localparam logic signed [RW-1:0]   HALF  = RW'(64'd1 << F);

  typedef struct packed {
    cmd_t                    cmd;
    logic [INDEX_BITS-1:0]   idx;
    logic [VALUE_BITS-1:0]   value;
    logic [2:0][BW-1:0]      bas_s;
    logic [2:0][BW-1:0]      bas_t;
    logic [2:0][BW-1:0]      bas_u;
    logic [POS_BITS-1:0]     x;
    logic [POS_BITS-1:0]     y;
    logic [POS_BITS-1:0]     z;
    logic                    last;
  } entry_t;

  function automatic logic signed [CLW-1:0] clamp(input logic [COORD_BITS-1:0] raw);
    logic signed [CMPW-1:0] c;
    c = CMPW'($signed(raw));
    if (c > ONE_C) begin
      c = ONE_C;
    end else if (c < -ONE_C) begin
      c = -ONE_C;
    end
    return c[CLW-1:0];
  endfunction

  // One-dimensional quadratic basis, exact at 2F+1 fraction bits, then
  // rounded half up to F fraction bits.
  function automatic logic [BW-1:0] basis(input logic signed [CLW-1:0] c,
                                          input logic [SQW-1:0] sq,
                                          input par_t p);
    logic signed [RW-1:0] cone;
    logic signed [RW-1:0] sqx;
    logic signed [RW-1:0] raw;
    logic signed [RW-1:0] rnd;
    cone = RW'(c) <<< F;
    sqx  = $signed(RW'(sq));
    case (p)
      PAR_N:   raw = sqx - cone;
      PAR_P:   raw = sqx + cone;
      default: raw = (ONE2 - sqx) <<< 1;
    endcase
    rnd = (raw + HALF) >>> (F + 1);
    return rnd[BW-1:0];
  endfunction

  // Stage A: clamped coordinates.
  logic                  a_valid;
  logic                  a_cmd;
  logic [INDEX_BITS-1:0] a_idx;
  logic [VALUE_BITS-1:0] a_value;
  logic signed [CLW-1:0] a_c [3];
  logic [POS_BITS-1:0]   a_x, a_y, a_z;
  logic                  a_last;

  // Stage B: coordinates and their squares.
  logic                  b_valid;
  logic                  b_cmd;
  logic [INDEX_BITS-1:0] b_idx;
  logic [VALUE_BITS-1:0] b_value;
  logic signed [CLW-1:0] b_c [3];
  logic [SQW-1:0]        b_sq [3];
  logic [POS_BITS-1:0]   b_x, b_y, b_z;
  logic                  b_last;

  logic signed [2*CLW-1:0] sq_full [3];
  logic                    en_a;
  logic                    en_b;
  entry_t                  ent;

  assign en_b     = !b_valid || q_ready;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;
  assign q_valid  = b_valid;
  assign q_data   = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= in_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = a_c[i] * a_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_cmd   <= in_cmd;
      a_idx   <= in_data[INDEX_BITS-1:0];
      a_value <= in_data[OFF_V +: VALUE_BITS];
      a_c[0]  <= clamp(in_data[OFF_S +: COORD_BITS]);
      a_c[1]  <= clamp(in_data[OFF_T +: COORD_BITS]);
      a_c[2]  <= clamp(in_data[OFF_U +: COORD_BITS]);
      a_x     <= in_data[OFF_X +: POS_BITS];
      a_y     <= in_data[OFF_Y +: POS_BITS];
      a_z     <= in_data[OFF_Z +: POS_BITS];
      a_last  <= in_last;
    end
    if (en_b && a_valid) begin
      b_cmd   <= a_cmd;
      b_idx   <= a_idx;
      b_value <= a_value;
      b_x     <= a_x;
      b_y     <= a_y;
      b_z     <= a_z;
      b_last  <= a_last;
      for (int i = 0; i < 3; i++) begin
        b_c[i]  <= a_c[i];
        b_sq[i] <= sq_full[i][SQW-1:0];
      end
    end
  end

  // Each axis gets its three bases, stored in the order of the par_t codes.
  always_comb begin
    ent.cmd   = cmd_t'(b_cmd);
    ent.idx   = b_idx;
    ent.value = b_value;
    ent.x     = b_x;
    ent.y     = b_y;
    ent.z     = b_z;
    ent.last  = b_last;
    for (int j = 0; j < 3; j++) begin
      ent.bas_s[j] = basis(b_c[0], b_sq[0], par_t'(2'(j)));
      ent.bas_t[j] = basis(b_c[1], b_sq[1], par_t'(2'(j)));
      ent.bas_u[j] = basis(b_c[2], b_sq[2], par_t'(2'(j)));
    end
  end

endmodule

// ----- rtl/h27i_back.sv -----
module h27i_back #(
  parameter int VALUE_BITS      = h27i_pkg::VALUE_BITS_DEF,
  parameter int COORD_FRAC_BITS = h27i_pkg::COORD_FRAC_BITS_DEF,
  parameter int ENTRY_BITS      = h27i_pkg::entry_bits(h27i_pkg::VALUE_BITS_DEF,
                                                       h27i_pkg::COORD_FRAC_BITS_DEF),
  parameter int OUT_BITS        = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [ENTRY_BITS-1:0] q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_data,
  output logic                out_sat,
  output logic                out_last
);

  import h27i_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int BW  = F + 2;
  localparam int P1W = 2 * BW;
  localparam int P2W = 3 * BW;
  localparam int TW  = BW + VALUE_BITS;
  localparam int AW  = TW + $clog2(NODE_COUNT);
  localparam int KW  = $clog2(NODE_COUNT);
  localparam int PIPE = 5;

  localparam logic signed [P2W-1:0] HALF_W = P2W'(64'd1 << (2 * F - 1));
  localparam logic signed [AW-1:0]  HALF_R = AW'(64'd1 << (F - 1));
  localparam logic signed [AW-1:0]  VMAX   = AW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0]  VMIN   = ~VMAX;

  typedef struct packed {
    cmd_t                    cmd;
    logic [INDEX_BITS-1:0]   idx;
    logic [VALUE_BITS-1:0]   value;
    logic [2:0][BW-1:0]      bas_s;
    logic [2:0][BW-1:0]      bas_t;
    logic [2:0][BW-1:0]      bas_u;
    logic [POS_BITS-1:0]     x;
    logic [POS_BITS-1:0]     y;
    logic [POS_BITS-1:0]     z;
    logic                    last;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  function automatic logic signed [BW-1:0] pick(input logic [2:0][BW-1:0] b,
                                                input par_t p);
    case (p)
      PAR_N:   return $signed(b[0]);
      PAR_P:   return $signed(b[2]);
      default: return $signed(b[1]);
    endcase
  endfunction

  entry_t                  ent;
  state_t                  state;
  logic [KW-1:0]           k;
  logic [PIPE-1:0]         vld;
  logic signed [AW-1:0]    acc;
  logic                    issue;
  logic                    load_now;
  logic                    finish;

  logic [VALUE_BITS-1:0]   mem [NODE_COUNT];
  logic [VALUE_BITS-1:0]   rdata;

  logic signed [BW-1:0]    bs0, bt0, bu0;
  logic signed [P1W-1:0]   p1;
  logic signed [BW-1:0]    bu1;
  logic [VALUE_BITS-1:0]   v1, v2, v3;
  logic signed [P2W-1:0]   p2;
  logic signed [P2W-1:0]   w_full;
  logic signed [BW-1:0]    w3;
  logic signed [TW-1:0]    t4;

  logic signed [AW-1:0]    rnd;
  logic                    sat_hi;
  logic                    sat_lo;
  logic [VALUE_BITS-1:0]   field;

  assign ent      = entry_t'(q_data);
  assign issue    = (state == ST_ISSUE);
  assign load_now = (state == ST_IDLE) && q_valid && (ent.cmd == CMD_LOAD);
  assign finish   = (state == ST_DRAIN) && (vld == '0) && (!out_valid || out_ready);
  assign q_ready  = load_now || finish;

  // Final rounding to an integer and saturation to the value range.
  always_comb begin
    rnd    = (acc + HALF_R) >>> F;
    sat_hi = (rnd > VMAX);
    sat_lo = (rnd < VMIN);
    if (sat_hi) begin
      field = VMAX[VALUE_BITS-1:0];
    end else if (sat_lo) begin
      field = VMIN[VALUE_BITS-1:0];
    end else begin
      field = rnd[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      vld <= {vld[PIPE-2:0], issue};
      if (vld[PIPE-1]) begin
        acc <= acc + AW'(t4);
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid && ent.cmd == CMD_SAMPLE) begin
            acc   <= '0;
            k     <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          k <= k + 1'b1;
          if (k == KW'(NODE_COUNT - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            out_valid <= 1'b1;
            out_data  <= OUT_BITS'({ent.z, ent.y, ent.x, field});
            out_sat   <= sat_hi || sat_lo;
            out_last  <= ent.last;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Node store: one write port for loads, one registered read for the sweep.
  always_ff @(posedge clk) begin
    if (load_now && ent.idx < INDEX_BITS'(NODE_COUNT)) begin
      mem[ent.idx] <= ent.value;
    end
    rdata <= mem[k];
  end

  // Weight and product pipeline, one node per cycle.
  assign w_full = (p2 + HALF_W) >>> (2 * F);

  always_ff @(posedge clk) begin
    bs0 <= pick(ent.bas_s, NODE_S[k]);
    bt0 <= pick(ent.bas_t, NODE_T[k]);
    bu0 <= pick(ent.bas_u, NODE_U[k]);
    p1  <= bs0 * bt0;
    bu1 <= bu0;
    v1  <= rdata;
    p2  <= p1 * bu1;
    v2  <= v1;
    w3  <= w_full[BW-1:0];
    v3  <= v2;
    t4  <= w3 * $signed(v3);
  end

endmodule

// ----- rtl/hex27_triquadratic_interpolator.sv -----
// Triquadratic interpolator over one 27-node quadratic hexahedron. Words come
// in on the s_axis stream: tuser selects the command (0 loads one node value
// into the node store, 1 evaluates one sample point). A load gives no output
// word; a sample gives exactly one m_axis word with the interpolated value,
// rounded half up and saturated to VALUE_BITS, a saturation flag in tuser,
// and the ray position and last flag passed through. Node values are
// undefined after reset until loaded, and every node a sample reads must be
// loaded first; there is no clearing pass. A two-stage front end clamps the
// coordinates and forms the nine one-dimensional basis values, then hands
// the word through a two-entry queue to the back end. A load is written into
// the node store by the idle back end. A sample holds the back end until its
// result is handed on: the idle back end takes it up and clears the
// accumulator, the single shared weight and multiply-accumulate pipeline
// takes one node a cycle from the node store's read port, that pipeline
// drains, and the result is rounded and handed to the output register. The
// front end keeps accepting words while the back end works until the queue
// is full, and the output register lets the back end go on while a result
// waits to be taken.
module hex27_triquadratic_interpolator #(
  parameter int VALUE_BITS      = h27i_pkg::VALUE_BITS_DEF,
  parameter int COORD_FRAC_BITS = h27i_pkg::COORD_FRAC_BITS_DEF,
  parameter int IN_TDATA_BITS   = ((h27i_pkg::INDEX_BITS + VALUE_BITS
                                    + 3 * h27i_pkg::COORD_BITS
                                    + 3 * h27i_pkg::POS_BITS + 7) / 8) * 8,
  parameter int OUT_TDATA_BITS  = ((VALUE_BITS + 3 * h27i_pkg::POS_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // From bit 0 up: node_index, node_value, coord_s, coord_t, coord_u,
  // pixel_x, pixel_y, depth_z, then zero fill.
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // cmd: 0 load, 1 sample.
  input  logic                      s_axis_tuser,
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // From bit 0 up: field_value, out_x, out_y, out_z, then zero fill.
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // saturated.
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast
);

  import h27i_pkg::*;

  localparam int ENTRY_BITS = entry_bits(VALUE_BITS, COORD_FRAC_BITS);

  logic                  fq_valid;
  logic                  fq_ready;
  logic [ENTRY_BITS-1:0] fq_data;
  logic                  qb_valid;
  logic                  qb_ready;
  logic [ENTRY_BITS-1:0] qb_data;

  h27i_front #(
    .VALUE_BITS      (VALUE_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .TDATA_BITS      (IN_TDATA_BITS),
    .ENTRY_BITS      (ENTRY_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_cmd   (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  h27i_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  h27i_back #(
    .VALUE_BITS      (VALUE_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .ENTRY_BITS      (ENTRY_BITS),
    .OUT_BITS        (OUT_TDATA_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_sat   (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- rtl/h27i_checker.sv -----
module h27i_checker #(
  parameter int VALUE_BITS     = 24,
  parameter int OUT_TDATA_BITS = 64
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input logic                      m_axis_tuser,
  input logic                      m_axis_tlast
);

  localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  // A clipped result must sit on one of the two range limits.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[VALUE_BITS-1:0] == VMAX || m_axis_tdata[VALUE_BITS-1:0] == VMIN)
    else $error("saturated result not at a range limit");

  // Nothing is presented right after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

endmodule

bind hex27_triquadratic_interpolator h27i_checker #(
  .VALUE_BITS     (VALUE_BITS),
  .OUT_TDATA_BITS (OUT_TDATA_BITS)
) u_h27i_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/tb_hex27_triquadratic_interpolator.sv -----
module tb_hex27_triquadratic_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  import h27i_pkg::*;

  localparam int FRAC = COORD_FRAC_BITS_DEF;
  localparam int VBITS = VALUE_BITS_DEF;
  localparam longint UNIT = longint'(1) << FRAC;
  localparam longint VMAX = (longint'(1) << (VBITS - 1)) - 1;
  localparam longint VMIN = -(longint'(1) << (VBITS - 1));
  localparam int IN_W = ((INDEX_BITS + VBITS + 3 * COORD_BITS + 3 * POS_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((VBITS + 3 * POS_BITS + 7) / 8) * 8;

  localparam int ITEM_TARGET = 1550;
  // Consecutive cycles without any accepted word before the run is declared hung.
  // The long output hold below is the largest legal quiet stretch.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AFTER = 40;
  // Margin after the last result; leave generous slack.
  localparam int TAIL_CYCLES = 100;

  // Parametric position of every node in hex27 order, one table per axis.
  localparam int AXIS_S [NODE_COUNT] = '{
    -1, 1, 1,-1,-1, 1, 1,-1,  0, 1, 0,-1,  0, 1, 0,-1,
    -1, 1, 1,-1,  0, 1, 0,-1,  0, 0, 0};
  localparam int AXIS_T [NODE_COUNT] = '{
    -1,-1, 1, 1,-1,-1, 1, 1, -1, 0, 1, 0, -1, 0, 1, 0,
    -1,-1, 1, 1, -1, 0, 1, 0,  0, 0, 0};
  localparam int AXIS_U [NODE_COUNT] = '{
    -1,-1,-1,-1, 1, 1, 1, 1, -1,-1,-1,-1,  1, 1, 1, 1,
     0, 0, 0, 0,  0, 0, 0, 0, -1, 1, 0};

  // One input word, unpacked.
  typedef struct {
    cmd_t        cmd;
    logic [4:0]  index;
    logic [23:0] value;
    logic [15:0] s, t, u;
    logic [11:0] x, y, z;
    logic        last;
  } in_word_t;

  // One interpolated sample as it should leave the block.
  typedef struct {
    logic [23:0] value;
    logic        sat;
    logic [11:0] x, y, z;
    logic        last;
  } sample_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;  // node_index, node_value, coord_s/t/u, pixel_x/y, depth_z
  logic                s_axis_tuser = 1'b0; // cmd
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;       // field_value, out_x, out_y, out_z
  logic                m_axis_tuser;       // saturated
  logic                m_axis_tlast;

  hex27_triquadratic_interpolator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Words waiting to be offered, the testbench copy of the node store, and the
  // samples whose results have not come back yet.
  in_word_t       word_queue [$];
  longint         node_store [NODE_COUNT];
  sample_result_t pending_samples [$];

  int  stim_count = 0;
  int  accepted_count = 0;
  int  result_count = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  logic s_fire = 1'b0;
  logic m_fire = 1'b0;

  // ---------------------------------------------------------------------------
  // Arithmetic of the interpolator. All rounding is half up: add one half of
  // the last kept place, then floor, which an arithmetic shift does for us.
  // ---------------------------------------------------------------------------
  function automatic longint round_half_up(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // Coordinates outside minus one to one are pulled back to the nearer bound.
  function automatic longint clamp_unit(logic [15:0] raw);
    longint c;
    c = longint'($signed(raw));
    if (c > UNIT) c = UNIT;
    if (c < -UNIT) c = -UNIT;
    return c;
  endfunction

  // One-dimensional quadratic Lagrange basis for node parameter p at c. The
  // exact product carries 2F+1 fraction bits and is rounded back to F.
  function automatic longint axis_basis(longint c, int p);
    longint prod;
    if (p != 0) prod = c * (c + p * UNIT);
    else prod = 2 * (UNIT * UNIT - c * c);
    return round_half_up(prod, FRAC + 1);
  endfunction

  function automatic sample_result_t interpolate(in_word_t w);
    sample_result_t r;
    longint cs, ct, cu, weight, acc, total;
    cs = clamp_unit(w.s);
    ct = clamp_unit(w.t);
    cu = clamp_unit(w.u);
    acc = 0;
    for (int k = 0; k < NODE_COUNT; k++) begin
      weight = round_half_up(axis_basis(cs, AXIS_S[k]) * axis_basis(ct, AXIS_T[k])
                             * axis_basis(cu, AXIS_U[k]), 2 * FRAC);
      acc += weight * node_store[k];
    end
    total = round_half_up(acc, FRAC);
    r.sat = 1'b0;
    if (total > VMAX) begin
      total = VMAX;
      r.sat = 1'b1;
    end
    if (total < VMIN) begin
      total = VMIN;
      r.sat = 1'b1;
    end
    r.value = total[23:0];
    r.x = w.x;
    r.y = w.y;
    r.z = w.z;
    r.last = w.last;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Packing of the input stream word, first field in the lowest bits.
  // ---------------------------------------------------------------------------
  function automatic logic [IN_W-1:0] pack_word(in_word_t w);
    return IN_W'({w.z, w.y, w.x, w.u, w.t, w.s, w.value, w.index});
  endfunction

  function automatic in_word_t unpack_word(logic [IN_W-1:0] d, logic user, logic last);
    in_word_t w;
    w.cmd = cmd_t'(user);
    w.index = d[4:0];
    w.value = d[28:5];
    w.s = d[44:29];
    w.t = d[60:45];
    w.u = d[76:61];
    w.x = d[88:77];
    w.y = d[100:89];
    w.z = d[112:101];
    w.last = last;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Fields that the command does not use still carry random bits, so the
  // block is shown that it must ignore them.
  function automatic in_word_t random_word();
    in_word_t w;
    w.cmd = CMD_LOAD;
    w.index = 5'($urandom);
    w.value = 24'($urandom);
    w.s = 16'($urandom);
    w.t = 16'($urandom);
    w.u = 16'($urandom);
    w.x = 12'($urandom);
    w.y = 12'($urandom);
    w.z = 12'($urandom);
    w.last = 1'($urandom);
    return w;
  endfunction

  function automatic longint rand_value();
    logic [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(0, 7))
      0: return VMAX;
      1: return VMIN;
      default: return longint'($signed(v));
    endcase
  endfunction

  // Mostly legal coordinates, some exact grid points and some raw 16-bit
  // patterns that the block has to clamp.
  function automatic longint rand_coord();
    logic [15:0] raw;
    raw = 16'($urandom);
    case ($urandom_range(0, 9))
      0: return longint'($signed(raw));
      1: begin
        case ($urandom_range(0, 4))
          0: return UNIT;
          1: return -UNIT;
          2: return 0;
          3: return UNIT / 2;
          default: return -UNIT / 2;
        endcase
      end
      default: return longint'($urandom_range(0, 32'(2 * UNIT))) - UNIT;
    endcase
  endfunction

  task automatic push_load(int idx, longint val);
    in_word_t w;
    w = random_word();
    w.cmd = CMD_LOAD;
    w.index = idx[4:0];
    w.value = val[23:0];
    word_queue.push_back(w);
    // A load to an index past the last node is dropped by the block.
    if (idx < NODE_COUNT) stim_count++;
  endtask

  task automatic push_sample(longint s, longint t, longint u, int x, int y, int z,
                             bit last);
    in_word_t w;
    w = random_word();
    w.cmd = CMD_SAMPLE;
    w.s = s[15:0];
    w.t = t[15:0];
    w.u = u[15:0];
    w.x = x[11:0];
    w.y = y[11:0];
    w.z = z[11:0];
    w.last = last;
    word_queue.push_back(w);
    stim_count++;
  endtask

  // For points inside the positive octant the weights of nodes with an odd
  // count of minus-one parameters are negative. Giving those nodes the
  // opposite extreme makes the weighted sum run past the value range.
  task automatic load_clip_pattern(bit negative);
    int minus_count;
    bit odd;
    for (int k = 0; k < NODE_COUNT; k++) begin
      minus_count = int'(AXIS_S[k] < 0) + int'(AXIS_T[k] < 0) + int'(AXIS_U[k] < 0);
      odd = minus_count[0];
      push_load(k, (odd ^ negative) ? VMIN : VMAX);
    end
  endtask

  task automatic build_stimulus();
    bit clip_round;
    int rays;
    bit last;
    longint s, t, u;
    // Every sample reads all 27 nodes, so the store is filled first, with
    // the value extremes among the entries.
    for (int k = 0; k < NODE_COUNT; k++) begin
      case (k)
        0: push_load(k, VMAX);
        1: push_load(k, VMIN);
        2: push_load(k, 0);
        3: push_load(k, 1);
        4: push_load(k, -1);
        default: push_load(k, rand_value());
      endcase
    end
    // Loads to indexes past the last node must leave the store alone.
    push_load(27, VMAX);
    push_load(31, VMIN);
    // Corners, center, half points and every pixel extreme.
    push_sample(-UNIT, -UNIT, -UNIT, 0, 0, 0, 1'b0);
    push_sample(UNIT, UNIT, UNIT, 4095, 4095, 4095, 1'b1);
    push_sample(0, 0, 0, 1, 2048, 4094, 1'b0);
    push_sample(UNIT / 2, -UNIT / 2, UNIT / 2, 2047, 1, 0, 1'b1);
    push_sample(-UNIT, 0, UNIT, 4095, 0, 4095, 1'b0);
    push_sample(1, -1, UNIT - 1, 0, 4095, 0, 1'b1);
    // Coordinates past minus one and one, up to the raw 16-bit extremes.
    push_sample(32767, -32768, UNIT + 1, $urandom, $urandom, $urandom, 1'b0);
    push_sample(-UNIT - 1, longint'(16'h4001), 0, $urandom, $urandom, $urandom, 1'b1);
    // A field pattern that pushes the sum past the top of the range.
    load_clip_pattern(1'b0);
    push_sample(UNIT / 2, UNIT / 2, UNIT / 2, $urandom, $urandom, $urandom, 1'b1);

    // Random part: a node set, then a ray of samples through it.
    while (stim_count < ITEM_TARGET) begin
      clip_round = 1'b0;
      case ($urandom_range(0, 9))
        0, 1: begin
          load_clip_pattern(1'($urandom_range(0, 1)));
          clip_round = 1'b1;
        end
        2, 3, 4: begin
          for (int k = 0; k < NODE_COUNT; k++) push_load(k, rand_value());
        end
        default: begin
          repeat ($urandom_range(0, 4)) push_load($urandom_range(0, 31), rand_value());
        end
      endcase
      rays = $urandom_range(1, 12);
      for (int j = 0; j < rays; j++) begin
        if (clip_round && $urandom_range(0, 3) != 0) begin
          s = longint'($urandom_range(3000, 13000));
          t = longint'($urandom_range(3000, 13000));
          u = longint'($urandom_range(3000, 13000));
        end else begin
          s = rand_coord();
          t = rand_coord();
          u = rand_coord();
        end
        last = (j == rays - 1) || ($urandom_range(0, 15) == 0);
        push_sample(s, t, u, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), last);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. Changes at the falling edge. After each accepted word it
  // waits a random number of cycles, except in calm stretches where it
  // streams back to back.
  // ---------------------------------------------------------------------------
  in_word_t cur_word;
  logic     send_valid;
  int       send_gap = 0;
  bit       send_calm = 1'b0;

  always @(negedge clk) begin
    send_valid = s_axis_tvalid;
    if (s_fire) begin
      send_valid = 1'b0;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      send_gap = send_calm ? 0 : $urandom_range(0, 18);
    end
    if (!rst && !send_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (word_queue.size() != 0) begin
        cur_word = word_queue.pop_front();
        s_axis_tdata <= pack_word(cur_word);
        s_axis_tuser <= cur_word.cmd;
        s_axis_tlast <= cur_word.last;
        send_valid = 1'b1;
      end
    end
    s_axis_tvalid <= send_valid;
  end

  // ---------------------------------------------------------------------------
  // Output side ready. Random stalls after each result word, calm stretches,
  // and once a long hold-off that lets the block fill up and stall its input.
  // ---------------------------------------------------------------------------
  int recv_gap = 0;
  bit recv_calm = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (m_fire) begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      recv_gap = recv_calm ? 0 : $urandom_range(0, 18);
    end
    if (!hold_done && result_count >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor at the rising edge: loads update the node copy, samples queue
  // their expected result, and every result word is checked against the
  // oldest waiting sample.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  in_word_t       seen_word;
  sample_result_t want;

  always @(posedge clk) begin
    s_fire <= s_axis_tvalid && s_axis_tready;
    m_fire <= m_axis_tvalid && m_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      accepted_count++;
      seen_word = unpack_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (seen_word.cmd == CMD_LOAD) begin
        if (seen_word.index < NODE_COUNT)
          node_store[seen_word.index] = longint'($signed(seen_word.value));
      end else begin
        pending_samples.push_back(interpolate(seen_word));
      end
    end
    if (m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (pending_samples.size() == 0) begin
        $error("result word with no sample waiting: tdata 0x%0h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        check_field("field_value", 32'(want.value), 32'(m_axis_tdata[23:0]));
        check_field("out_x", 32'(want.x), 32'(m_axis_tdata[35:24]));
        check_field("out_y", 32'(want.y), 32'(m_axis_tdata[47:36]));
        check_field("out_z", 32'(want.z), 32'(m_axis_tdata[59:48]));
        check_field("tdata fill", 0, 32'(m_axis_tdata[OUT_W-1:60]));
        check_field("saturated", 32'(want.sat), 32'(m_axis_tuser));
        check_field("last_out", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // Hang detector: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hex27_triquadratic_interpolator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build all stimulus, hold reset, then wait until every word is
  // taken and every sample has returned, plus a drain margin.
  // ---------------------------------------------------------------------------
  int total_words;

  initial begin
    build_stimulus();
    total_words = word_queue.size();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (accepted_count < total_words || pending_samples.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("hex27_triquadratic_interpolator verification clean");
    end else begin
      $display("hex27_triquadratic_interpolator verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/h27i_pkg.sv
rtl/h27i_queue.sv
rtl/h27i_front.sv
rtl/h27i_back.sv
rtl/hex27_triquadratic_interpolator.sv
rtl/h27i_checker.sv
verif/tb_hex27_triquadratic_interpolator.sv
